// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the LCS length block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LCSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LCSL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lcsl_pkg.sv =====
// Package with the constants, word types and control types of the LCS length block.
`default_nettype none

package lcsl_pkg;

  localparam int MAX_LEN    = 512;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_LEN);
  localparam int CNT_W      = $clog2(MAX_LEN + 1);

  localparam logic [1:0] CMD_APPEND_A = 2'd0;
  localparam logic [1:0] CMD_APPEND_B = 2'd1;
  localparam logic [1:0] CMD_COMPUTE  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] value;
  } in_word_t;

  typedef struct packed {
    logic [9:0] match_count;
    logic       overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_A,
    ST_CELLS,
    ST_ROW_END,
    ST_FINISH
  } lcsl_state_t;

  typedef struct packed {
    logic             row_start;
    logic             first_row;
    logic             issue;
    logic [IDX_W-1:0] rd_idx;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/lcsl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lcsl_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcsl_cell.sv =====
// Dynamic-program cell datapath with the row memory it reads and writes back.
`default_nettype none

module lcsl_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire lcsl_pkg::cell_ctrl_t             ctrl,
  input  wire logic [lcsl_pkg::VALUE_BITS-1:0]  a_val,
  input  wire logic [lcsl_pkg::VALUE_BITS-1:0]  b_val,
  output logic      [lcsl_pkg::CNT_W-1:0]       result
);

  logic                           s1_valid_r;
  logic [lcsl_pkg::IDX_W-1:0]     s1_idx_r;
  logic [lcsl_pkg::CNT_W-1:0]     diag_r;
  logic [lcsl_pkg::CNT_W-1:0]     left_r;
  logic [lcsl_pkg::CNT_W-1:0]     row_rdata;
  logic [lcsl_pkg::CNT_W-1:0]     above;
  logic [lcsl_pkg::CNT_W-1:0]     cell_val;

  // Entry k of the row memory holds column k+1; column zero is always zero.
  lcsl_ram #(
    .DEPTH(lcsl_pkg::MAX_LEN),
    .WIDTH(lcsl_pkg::CNT_W)
  ) u_row_mem (
    .clk  (clk),
    .we   (s1_valid_r),
    .waddr(s1_idx_r),
    .wdata(cell_val),
    .re   (ctrl.issue),
    .raddr(ctrl.rd_idx),
    .rdata(row_rdata)
  );

  // The first row sees an all-zero row above it, so the memory needs no clearing.
  assign above = ctrl.first_row ? '0 : row_rdata;

  always_comb begin
    if (a_val == b_val) begin
      cell_val = diag_r + lcsl_pkg::CNT_W'(1);
    end else if (above > left_r) begin
      cell_val = above;
    end else begin
      cell_val = left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= ctrl.rd_idx;
    if (ctrl.row_start) begin
      diag_r <= '0;
      left_r <= '0;
    end else if (s1_valid_r) begin
      diag_r <= above;
      left_r <= cell_val;
    end
  end

  assign result = left_r;

endmodule

`default_nettype wire

// ===== rtl/lcsl_ctrl.sv =====
// Sequencer that walks the dynamic program row by row and column by column.
`default_nettype none

module lcsl_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [lcsl_pkg::CNT_W-1:0]  len_a,
  input  wire logic [lcsl_pkg::CNT_W-1:0]  len_b,
  output lcsl_pkg::cell_ctrl_t             ctrl,
  output logic                             a_rd_en,
  output logic      [lcsl_pkg::IDX_W-1:0]  a_rd_idx,
  output logic                             busy,
  output logic                             done
);

  lcsl_pkg::lcsl_state_t        state_r, state_nxt;
  logic [lcsl_pkg::IDX_W-1:0]   row_r, row_nxt;
  logic [lcsl_pkg::IDX_W-1:0]   col_r, col_nxt;
  logic                         first_row_r, first_row_nxt;
  logic                         last_col;
  logic                         last_row;

  assign last_col = (lcsl_pkg::CNT_W'(col_r) + lcsl_pkg::CNT_W'(1)) == len_b;
  assign last_row = (lcsl_pkg::CNT_W'(row_r) + lcsl_pkg::CNT_W'(1)) == len_a;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcsl_pkg::ST_IDLE: begin
        if (start) state_nxt = lcsl_pkg::ST_LOAD_A;
      end
      lcsl_pkg::ST_LOAD_A: begin
        state_nxt = lcsl_pkg::ST_CELLS;
      end
      lcsl_pkg::ST_CELLS: begin
        if (last_col) state_nxt = lcsl_pkg::ST_ROW_END;
      end
      lcsl_pkg::ST_ROW_END: begin
        state_nxt = last_row ? lcsl_pkg::ST_FINISH : lcsl_pkg::ST_LOAD_A;
      end
      lcsl_pkg::ST_FINISH: begin
        state_nxt = lcsl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lcsl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    first_row_nxt = first_row_r;
    if (state_r == lcsl_pkg::ST_IDLE && start) begin
      row_nxt       = '0;
      first_row_nxt = 1'b1;
    end
    if (state_r == lcsl_pkg::ST_LOAD_A) begin
      col_nxt = '0;
    end
    if (state_r == lcsl_pkg::ST_CELLS) begin
      col_nxt = col_r + lcsl_pkg::IDX_W'(1);
    end
    if (state_r == lcsl_pkg::ST_ROW_END) begin
      first_row_nxt = 1'b0;
      if (!last_row) row_nxt = row_r + lcsl_pkg::IDX_W'(1);
    end
  end

  always_comb begin
    ctrl.row_start = (state_r == lcsl_pkg::ST_LOAD_A);
    ctrl.first_row = first_row_r;
    ctrl.issue     = (state_r == lcsl_pkg::ST_CELLS);
    ctrl.rd_idx    = col_r;
    a_rd_en        = (state_r == lcsl_pkg::ST_LOAD_A);
    a_rd_idx       = row_r;
    busy           = (state_r != lcsl_pkg::ST_IDLE);
    done           = (state_r == lcsl_pkg::ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcsl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    first_row_r <= first_row_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/longest_common_subsequence_length.sv =====
// Top level of the longest common subsequence length block.
`default_nettype none

// Words with cmd 0 or 1 append their value to sequence A or B, one word per
// cycle while no compute runs, and give no result; an append to a sequence
// that already holds MAX_LEN elements is dropped and raises the sticky
// overflow flag. A word with cmd 2 runs the classic row-by-row dynamic program
// over the two sequences and returns one word with the subsequence length and
// the overflow flag, then clears both sequences and the flag. Words with cmd 3
// are taken and ignored. The two sequences and the dynamic-program row each
// live in a synchronous memory with registered read data. The row memory is
// read, updated and written back one cell per cycle. Each row has a state that
// fetches its A element and a state that retires the last cell before the next
// row starts, and a final state hands the length to the output. A compute
// keeps the input stalled through that final state, and the result word is
// presented in the cycle right after it; a compute with either sequence empty
// returns zero in the next cycle. Appends are still taken while a result waits
// at the output; a new compute waits until that result has been taken. No
// clearing pass is needed after reset: the first row of every compute treats
// the row above it as zero.
module longest_common_subsequence_length (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lcsl_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lcsl_pkg::out_word_t      out_word
);

  logic [lcsl_pkg::CNT_W-1:0]       count_a_r, count_b_r;
  logic                             dropped_r;
  logic                             out_valid_r;
  lcsl_pkg::out_word_t              out_word_r;

  logic                             in_accept;
  logic                             is_append_a, is_append_b, is_compute;
  logic                             full_a, full_b;
  logic                             seq_empty;
  logic                             start;
  logic                             busy;
  logic                             done;
  logic                             a_rd_en;
  logic [lcsl_pkg::IDX_W-1:0]       a_rd_idx;
  lcsl_pkg::cell_ctrl_t             ctrl;
  logic [lcsl_pkg::VALUE_BITS-1:0]  a_val, b_val;
  logic [lcsl_pkg::VALUE_BITS-1:0]  append_val;
  logic [lcsl_pkg::CNT_W-1:0]       result;

  assign is_append_a = (in_word.cmd == lcsl_pkg::CMD_APPEND_A);
  assign is_append_b = (in_word.cmd == lcsl_pkg::CMD_APPEND_B);
  assign is_compute  = (in_word.cmd == lcsl_pkg::CMD_COMPUTE);

  // A compute is held back while the previous result still waits.
  assign in_stall  = busy || (in_valid && is_compute && out_valid_r);
  assign in_accept = in_valid && !in_stall;

  assign full_a     = (count_a_r == lcsl_pkg::CNT_W'(lcsl_pkg::MAX_LEN));
  assign full_b     = (count_b_r == lcsl_pkg::CNT_W'(lcsl_pkg::MAX_LEN));
  assign seq_empty  = (count_a_r == '0) || (count_b_r == '0);
  assign start      = in_accept && is_compute && !seq_empty;
  assign append_val = in_word.value[lcsl_pkg::VALUE_BITS-1:0];

  lcsl_ram #(
    .DEPTH(lcsl_pkg::MAX_LEN),
    .WIDTH(lcsl_pkg::VALUE_BITS)
  ) u_seq_a (
    .clk  (clk),
    .we   (in_accept && is_append_a && !full_a),
    .waddr(count_a_r[lcsl_pkg::IDX_W-1:0]),
    .wdata(append_val),
    .re   (a_rd_en),
    .raddr(a_rd_idx),
    .rdata(a_val)
  );

  // Sequence B is read in step with the row memory, one column per cycle.
  lcsl_ram #(
    .DEPTH(lcsl_pkg::MAX_LEN),
    .WIDTH(lcsl_pkg::VALUE_BITS)
  ) u_seq_b (
    .clk  (clk),
    .we   (in_accept && is_append_b && !full_b),
    .waddr(count_b_r[lcsl_pkg::IDX_W-1:0]),
    .wdata(append_val),
    .re   (ctrl.issue),
    .raddr(ctrl.rd_idx),
    .rdata(b_val)
  );

  lcsl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .len_a   (count_a_r),
    .len_b   (count_b_r),
    .ctrl    (ctrl),
    .a_rd_en (a_rd_en),
    .a_rd_idx(a_rd_idx),
    .busy    (busy),
    .done    (done)
  );

  lcsl_cell u_cell (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .a_val (a_val),
    .b_val (b_val),
    .result(result)
  );

  // Sequence counts and the sticky drop flag; a finished compute, or one over an empty sequence, clears them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= '0;
      count_b_r <= '0;
      dropped_r <= 1'b0;
    end else if (done || (in_accept && is_compute && seq_empty)) begin
      count_a_r <= '0;
      count_b_r <= '0;
      dropped_r <= 1'b0;
    end else if (in_accept && is_append_a) begin
      if (full_a) begin
        dropped_r <= 1'b1;
      end else begin
        count_a_r <= count_a_r + lcsl_pkg::CNT_W'(1);
      end
    end else if (in_accept && is_append_b) begin
      if (full_b) begin
        dropped_r <= 1'b1;
      end else begin
        count_b_r <= count_b_r + lcsl_pkg::CNT_W'(1);
      end
    end
  end

  // Output register; it is always empty when a compute finishes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done || (in_accept && is_compute && seq_empty)) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_word_r.match_count <= 10'(result);
      out_word_r.overflow    <= dropped_r;
    end else if (in_accept && is_compute && seq_empty) begin
      out_word_r.match_count <= '0;
      out_word_r.overflow    <= dropped_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`include "assert_macros.svh"

  `LCSL_ASSERT(a_count_bound, (count_a_r <= lcsl_pkg::CNT_W'(lcsl_pkg::MAX_LEN)) && (count_b_r <= lcsl_pkg::CNT_W'(lcsl_pkg::MAX_LEN)), "sequence count beyond capacity")
  `LCSL_ASSERT_SAME(a_done_out_free, done, !out_valid_r, "compute finished while result register full")
  `LCSL_ASSERT_SAME(a_result_bound, done, (result <= count_a_r) && (result <= count_b_r), "subsequence length exceeds a sequence length")
  `LCSL_ASSERT_NEXT(a_done_clears, done, (count_a_r == '0) && (count_b_r == '0) && !dropped_r && out_valid_r, "compute end did not clear state or post result")

endmodule

`default_nettype wire

// ===== test/longest_common_subsequence_length_tb.sv =====
// Testbench for the LCS length block: directed and random append and compute words against a predictor.
`timescale 1ns / 1ps

// Words flow from a queue of pending input words into a clocked driver that
// inserts random gaps. A clocked monitor feeds every accepted input word to a
// predictor of the subsequence length and compares every accepted result word
// with the oldest prediction. The receiver stalls at random. Each time the
// result count reaches the next mark it holds off for a long stretch, so that
// a compute backs up behind the waiting result and the block stalls its input.
module longest_common_subsequence_length_tb;

  // The block takes and drops words with this code. The package has no name for it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // A full 512 by 512 compute keeps both channels quiet while it runs, so the
  // watchdog limit has to outlast it before it gives up.
  localparam int QUIET_LIMIT    = 1_000_000;
  localparam int SQUEEZE_CYCLES = 500;
  localparam int TARGET_WORDS   = 1250;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  lcsl_pkg::in_word_t  in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lcsl_pkg::out_word_t out_word;

  longest_common_subsequence_length dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #2 clk = ~clk;

  // Words waiting to be offered, and the results that the predictor expects.
  lcsl_pkg::in_word_t  pending_words[$];
  lcsl_pkg::out_word_t lcs_results_due[$];

  // Predictor state: both sequences, their fill levels and the sticky drop flag.
  logic [lcsl_pkg::VALUE_BITS-1:0] seq_a[lcsl_pkg::MAX_LEN];
  logic [lcsl_pkg::VALUE_BITS-1:0] seq_b[lcsl_pkg::MAX_LEN];
  int unsigned                     fill_a = 0;
  int unsigned                     fill_b = 0;
  logic                            append_lost = 1'b0;

  int errors        = 0;
  int words_made    = 0;
  int results_seen  = 0;
  int squeeze_mark  = 4;
  int send_gap_left = 0;
  int send_calm     = 0;
  int recv_calm     = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;

  // Gap lengths: mostly none or short, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  // The sender now and then runs a stretch of words back to back.
  function automatic int sender_gap();
    if (send_calm != 0) begin
      send_calm--;
      return 0;
    end
    if ($urandom_range(0, 149) == 0) send_calm = 60;
    return pick_gap();
  endfunction

  function automatic int receiver_pause();
    if (recv_calm != 0) begin
      recv_calm--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) recv_calm = 150;
    return ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
  endfunction

  // Row-by-row dynamic program over a single row: each cell takes the diagonal
  // plus one on a match, otherwise the larger of the cell above and the cell to the left.
  function automatic logic [9:0] lcs_length();
    int row[0:lcsl_pkg::MAX_LEN];
    int corner;
    int north;
    int west;
    for (int j = 0; j <= lcsl_pkg::MAX_LEN; j++) row[j] = 0;
    for (int i = 0; i < fill_a; i++) begin
      corner = 0;
      for (int j = 1; j <= fill_b; j++) begin
        north = row[j];
        if (seq_a[i] == seq_b[j-1]) begin
          row[j] = corner + 1;
        end else begin
          west   = row[j-1];
          row[j] = (north > west) ? north : west;
        end
        corner = north;
      end
    end
    return 10'(row[fill_b]);
  endfunction

  // Applies one accepted input word to the predictor state.
  function automatic void apply_word(lcsl_pkg::in_word_t w);
    lcsl_pkg::out_word_t res;
    case (w.cmd)
      lcsl_pkg::CMD_APPEND_A: begin
        if (fill_a < lcsl_pkg::MAX_LEN) begin
          seq_a[fill_a] = w.value;
          fill_a++;
        end else begin
          append_lost = 1'b1;
        end
      end
      lcsl_pkg::CMD_APPEND_B: begin
        if (fill_b < lcsl_pkg::MAX_LEN) begin
          seq_b[fill_b] = w.value;
          fill_b++;
        end else begin
          append_lost = 1'b1;
        end
      end
      lcsl_pkg::CMD_COMPUTE: begin
        res.match_count = lcs_length();
        res.overflow    = append_lost;
        lcs_results_due = {lcs_results_due, res};
        fill_a      = 0;
        fill_b      = 0;
        append_lost = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic push_word(logic [1:0] cmd, logic [15:0] value);
    lcsl_pkg::in_word_t w;
    w.cmd   = cmd;
    w.value = value;
    pending_words = {pending_words, w};
    // Ignored words do not count toward the stimulus size.
    if (cmd != CMD_UNUSED) words_made++;
  endtask

  // Value styles: a tiny alphabet gives many matches, full-range values give
  // few, and values at all ones or one bit away from it catch a comparator
  // that ignores some bits.
  function automatic logic [15:0] pick_value(int flavor);
    case (flavor)
      0:       return 16'($urandom_range(0, 3));
      1:       return 16'($urandom);
      default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                                  : 16'hFFFF ^ (16'h1 << $urandom_range(0, 15));
    endcase
  endfunction

  // Loads both sequences with their appends interleaved at random, sprinkles
  // in a few ignored words, and closes with a compute.
  task automatic load_and_compute(int na, int nb, int flavor);
    int left_a;
    int left_b;
    left_a = na;
    left_b = nb;
    while (left_a + left_b > 0) begin
      if ($urandom_range(0, 99) < 3) push_word(CMD_UNUSED, 16'($urandom));
      if (left_b == 0 || (left_a != 0 && $urandom_range(0, 1) == 0)) begin
        push_word(lcsl_pkg::CMD_APPEND_A, pick_value(flavor));
        left_a--;
      end else begin
        push_word(lcsl_pkg::CMD_APPEND_B, pick_value(flavor));
        left_b--;
      end
    end
    push_word(lcsl_pkg::CMD_COMPUTE, 16'($urandom));
  endtask

  // Random computes, most of them short so that the dynamic program stays cheap.
  task automatic random_computes(int until_words);
    int r;
    int na;
    int nb;
    while (words_made < until_words) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        na = $urandom_range(0, 8);
        nb = $urandom_range(0, 8);
      end else if (r < 95) begin
        na = $urandom_range(0, 24);
        nb = $urandom_range(0, 24);
      end else begin
        na = $urandom_range(25, 60);
        nb = $urandom_range(25, 60);
      end
      load_and_compute(na, nb, $urandom_range(0, 2));
    end
  endtask

  // Both sequences filled to the brim with the same values, so the length is
  // the largest a compute can give, MAX_LEN. One more append to each sequence is dropped.
  task automatic full_identical_compute();
    logic [15:0] vals[lcsl_pkg::MAX_LEN];
    for (int k = 0; k < lcsl_pkg::MAX_LEN; k++) begin
      vals[k] = 16'($urandom);
      push_word(lcsl_pkg::CMD_APPEND_A, vals[k]);
    end
    push_word(lcsl_pkg::CMD_APPEND_A, 16'($urandom));
    for (int k = 0; k < lcsl_pkg::MAX_LEN; k++) push_word(lcsl_pkg::CMD_APPEND_B, vals[k]);
    push_word(lcsl_pkg::CMD_APPEND_B, 16'($urandom));
    push_word(lcsl_pkg::CMD_COMPUTE, 16'h0000);
  endtask

  // Driver: a word that is offered stays put until it is taken. After that
  // the line either idles for a random gap or carries the next pending word.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      send_gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap_left != 0) begin
        in_valid      <= 1'b0;
        send_gap_left <= send_gap_left - 1;
      end else if (pending_words.size() != 0) begin
        in_word       <= pending_words[0];
        pending_words.delete(0);
        in_valid      <= 1'b1;
        send_gap_left <= sender_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off each time the result count
  // reaches the next mark. The sender keeps going during a hold-off, so the
  // next compute waits behind the result that has not been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (results_seen >= squeeze_mark) begin
      out_stall    <= 1'b1;
      stall_left   <= SQUEEZE_CYCLES;
      squeeze_mark <= squeeze_mark * 4;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= receiver_pause();
    end
  end

  // Monitor: accepted input words feed the predictor, and accepted result
  // words are checked against the oldest prediction.
  always @(posedge clk) begin
    lcsl_pkg::out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) apply_word(in_word);
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (lcs_results_due.size() == 0) begin
          errors++;
          $error("unexpected result: match_count %0d overflow %0b",
                 out_word.match_count, out_word.overflow);
        end else begin
          want = lcs_results_due[0];
          lcs_results_due.delete(0);
          if (out_word.match_count !== want.match_count) begin
            errors++;
            $error("match_count: expected %0d, got %0d", want.match_count, out_word.match_count);
          end
          if (out_word.overflow !== want.overflow) begin
            errors++;
            $error("overflow: expected %0b, got %0b", want.overflow, out_word.overflow);
          end
        end
      end
    end
  end

  // Watchdog: a run in which nothing moves on either side for too long has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Directed words. First a compute with both sequences empty.
    push_word(lcsl_pkg::CMD_COMPUTE, 16'hFFFF);
    // Only A holds an element.
    push_word(lcsl_pkg::CMD_APPEND_A, 16'h0000);
    push_word(lcsl_pkg::CMD_COMPUTE, 16'h0000);
    // Only B holds an element.
    push_word(lcsl_pkg::CMD_APPEND_B, 16'hFFFF);
    push_word(lcsl_pkg::CMD_COMPUTE, 16'h0000);
    // Ignored words between appends must leave the sequences alone.
    push_word(CMD_UNUSED, 16'hFFFF);
    push_word(lcsl_pkg::CMD_APPEND_A, 16'hFFFF);
    push_word(CMD_UNUSED, 16'h0000);
    push_word(lcsl_pkg::CMD_APPEND_B, 16'hFFFF);
    push_word(lcsl_pkg::CMD_COMPUTE, 16'hFFFF);
    // Alternating bit patterns in crossed order: only one line can be drawn.
    push_word(lcsl_pkg::CMD_APPEND_A, 16'hAAAA);
    push_word(lcsl_pkg::CMD_APPEND_A, 16'h5555);
    push_word(lcsl_pkg::CMD_APPEND_B, 16'h5555);
    push_word(lcsl_pkg::CMD_APPEND_B, 16'hAAAA);
    push_word(lcsl_pkg::CMD_COMPUTE, 16'h5555);
    // Top and bottom bits alone, with a common subsequence of two.
    push_word(lcsl_pkg::CMD_APPEND_A, 16'h8000);
    push_word(lcsl_pkg::CMD_APPEND_A, 16'h0001);
    push_word(lcsl_pkg::CMD_APPEND_A, 16'h8000);
    push_word(lcsl_pkg::CMD_APPEND_B, 16'h0001);
    push_word(lcsl_pkg::CMD_APPEND_B, 16'h8000);
    push_word(lcsl_pkg::CMD_APPEND_B, 16'h0001);
    push_word(lcsl_pkg::CMD_COMPUTE, 16'h0000);

    // Random computes, with the full-size case placed among them.
    random_computes(100);
    full_identical_compute();
    random_computes(TARGET_WORDS);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until the last word has been taken and every result has arrived,
    // then keep the clock running so that any stray result shows.
    while (pending_words.size() != 0 || in_valid) @(negedge clk);
    while (lcs_results_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
